>>> hw/rtl/dmd_pkg.sv
// Shared types, widths and a helper function for the depth mip downsample block.
package dmd_pkg;

   // Design limits.
   localparam int MAX_WIDTH  = 4096;
   localparam int DEPTH_BITS = 16;

   // Widths of the configuration registers and of the position counters.
   localparam int CFG_W  = 13;
   localparam int SIZE_W = $clog2(MAX_WIDTH + 1);
   localparam int COL_W  = $clog2(MAX_WIDTH);

   // Pair store geometry: one entry per horizontal pair of the upper row.
   localparam int PAIR_DEPTH = MAX_WIDTH / 2;
   localparam int IDX_W      = $clog2(PAIR_DEPTH);
   localparam int PSUM_W     = DEPTH_BITS + 1;
   localparam int PCNT_W     = 2;
   localparam int ENTRY_W    = PSUM_W + PCNT_W;

   // Block totals over four samples.
   localparam int TSUM_W = DEPTH_BITS + 2;
   localparam int TCNT_W = 3;

   // Reciprocal of three, exact for every block total below 2**TSUM_W.
   localparam int RECIP3_SHIFT = TSUM_W + 2;
   localparam int RECIP_W      = TSUM_W + 1;
   localparam logic [RECIP_W-1:0] RECIP3 = RECIP_W'(((64'd1 << RECIP3_SHIFT) + 64'd2) / 64'd3);
   localparam int PROD_W       = TSUM_W + RECIP_W;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [0:0] {
      CSR_SRC_WIDTH  = 1'b0,
      CSR_SRC_HEIGHT = 1'b1
   } csr_reg_type;

   // Reset values of the size registers.
   localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(2);

   // Saturate a programmed size into the range the block supports.
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0] v);
      logic [SIZE_W-1:0] r;
      if (32'(v) < 32'd2) begin
         r = SIZE_W'(2);
      end else if (32'(v) > 32'(MAX_WIDTH)) begin
         r = SIZE_W'(MAX_WIDTH);
      end else begin
         r = SIZE_W'(v);
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/dmd_if.sv
// Stream interfaces for the source pixel channel and the mip pixel channel.
interface dmd_req_if import dmd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [DEPTH_BITS-1:0] depth_in;

   modport source (output valid, output depth_in, input ready);
   modport sink   (input valid, input depth_in, output ready);
endinterface

interface dmd_rsp_if import dmd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [DEPTH_BITS-1:0] depth_out;
   logic                  end_of_row;
   logic                  end_of_frame;

   modport source (output valid, output depth_out, output end_of_row, output end_of_frame,
                   input ready);
   modport sink   (input valid, input depth_out, input end_of_row, input end_of_frame,
                   output ready);
endinterface

>>> hw/rtl/dmd_ram.sv
// Generic single-port RAM with a registered read port.
module dmd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and read; the read data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/depth_mip_downsample_unit.sv
// Top level of the 2x2 depth mip downsampler with its pair store and output stage.
//
// Usage: source depth pixels arrive in row-major order on req_bus, one beat per pixel.
// Each 2x2 block of the source gives one beat on rsp_bus carrying the mean of its
// nonzero samples (0 when none is nonzero), with end_of_row and end_of_frame marks.
// An odd last column or row gives no beats. Sizes are set through the csr_ port;
// any size write restarts the pass at the top-left pixel.
// Throughput: one source beat per cycle, except while a receiver stall holds req_bus.ready
// low. The upper row of a block leaves its pair sums in a 2048-entry single-port RAM; the
// lower row reads them back, and the RAM port sees at most one access per beat.
// The lower-right pixel of a block starts the RAM read and loads the internal stage in the
// same cycle; the combine and divide then land in the output register.
// Reset clears the position counters, the stage valids and sets both sizes to 2.
// The pair store is not cleared; the upper row always writes an entry before use.
// When the receiver stalls, the output register and one internal stage hold beats,
// and req_bus.ready drops once both are full.
module depth_mip_downsample_unit import dmd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   dmd_req_if.sink               req_bus,
   dmd_rsp_if.source             rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // Configuration and position state.
   logic [CFG_W-1:0]      width_ff, width_in;
   logic [CFG_W-1:0]      height_ff, height_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [COL_W-1:0]      row_ff, row_in;
   logic [DEPTH_BITS-1:0] held_ff, held_in;

   // Stage after the RAM read.
   logic                  s1_valid_ff, s1_valid_in;
   logic [PSUM_W-1:0]     s1_sum_ff, s1_sum_in;
   logic [PCNT_W-1:0]     s1_cnt_ff, s1_cnt_in;
   logic                  s1_eor_ff, s1_eor_in;
   logic                  s1_eof_ff, s1_eof_in;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DEPTH_BITS-1:0] rsp_depth_ff, rsp_depth_in;
   logic                  rsp_eor_ff, rsp_eor_in;
   logic                  rsp_eof_ff, rsp_eof_in;

   logic                  cfg_wr;
   csr_reg_type           cfg_reg;
   logic [SIZE_W-1:0]     eff_w, eff_h, out_w, out_h;
   logic [COL_W-1:0]      col, row;
   logic                  last_col, last_row;
   logic [IDX_W-1:0]      pair_idx;
   logic                  pair_ok, eor, eof;
   logic [PSUM_W-1:0]     psum;
   logic [PCNT_W-1:0]     pcnt;
   logic                  out_free, req_ready, accept, ram_we, ram_re;
   logic [ENTRY_W-1:0]    ram_rdata;
   logic [TSUM_W-1:0]     tsum;
   logic [TCNT_W-1:0]     tcnt;
   logic [PROD_W-1:0]     prod3;
   logic [DEPTH_BITS-1:0] mean;

   // Register port: writes complete in the access phase, reads are immediate.
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_reg    = csr_reg_type'(csr_paddr[2]);

   always_comb begin
      unique case (cfg_reg)
         CSR_SRC_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         CSR_SRC_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Effective sizes and the current source position.
   assign eff_w = clamp_size(width_ff);
   assign eff_h = clamp_size(height_ff);
   assign out_w = eff_w >> 1;
   assign out_h = eff_h >> 1;

   always_comb begin
      col = (SIZE_W'(col_ff) >= eff_w) ? COL_W'(eff_w - SIZE_W'(1)) : col_ff;
      row = (SIZE_W'(row_ff) >= eff_h) ? COL_W'(eff_h - SIZE_W'(1)) : row_ff;
   end

   assign last_col = (SIZE_W'(col) + SIZE_W'(1)) >= eff_w;
   assign last_row = (SIZE_W'(row) + SIZE_W'(1)) >= eff_h;
   assign pair_idx = col[COL_W-1:1];
   assign pair_ok  = col[0] && (SIZE_W'(pair_idx) < out_w) && (SIZE_W'(row[COL_W-1:1]) < out_h);
   assign eor      = SIZE_W'(pair_idx) == (out_w - SIZE_W'(1));
   assign eof      = eor && (SIZE_W'(row[COL_W-1:1]) == (out_h - SIZE_W'(1)));

   // Horizontal pair sum and count of nonzero samples.
   always_comb begin
      psum = '0;
      pcnt = '0;
      if (held_ff != '0) begin
         psum = psum + PSUM_W'(held_ff);
         pcnt = pcnt + PCNT_W'(1);
      end
      if (req_bus.depth_in != '0) begin
         psum = psum + PSUM_W'(req_bus.depth_in);
         pcnt = pcnt + PCNT_W'(1);
      end
   end

   // Flow control: the internal stage moves when the output register frees up.
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_ready     = !s1_valid_ff || out_free;
   assign req_bus.ready = req_ready;
   assign accept        = req_bus.valid && req_ready;
   assign ram_we        = accept && pair_ok && !row[0];
   assign ram_re        = accept && pair_ok && row[0];

   // Pair store: upper rows write, lower rows read back.
   dmd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (PAIR_DEPTH)
   ) u_pair_ram (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (pair_idx),
      .wdata ({pcnt, psum}),
      .rdata (ram_rdata)
   );

   // Block total and its mean; the count is 0 to 4.
   assign tsum  = TSUM_W'(s1_sum_ff) + TSUM_W'(ram_rdata[PSUM_W-1:0]);
   assign tcnt  = TCNT_W'(s1_cnt_ff) + TCNT_W'(ram_rdata[ENTRY_W-1:PSUM_W]);
   assign prod3 = PROD_W'(tsum) * PROD_W'(RECIP3);

   always_comb begin
      unique case (tcnt)
         3'd1:    mean = DEPTH_BITS'(tsum);
         3'd2:    mean = DEPTH_BITS'(tsum >> 1);
         3'd3:    mean = prod3[RECIP3_SHIFT +: DEPTH_BITS];
         3'd4:    mean = DEPTH_BITS'(tsum >> 2);
         default: mean = '0;
      endcase
   end

   // Next-state logic for configuration, position and held pixel.
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      held_in   = held_ff;
      if (cfg_wr) begin
         unique case (cfg_reg)
            CSR_SRC_WIDTH:  width_in  = csr_pwdata[CFG_W-1:0];
            CSR_SRC_HEIGHT: height_in = csr_pwdata[CFG_W-1:0];
            default:        width_in  = width_ff;
         endcase
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (!col[0]) begin
            held_in = req_bus.depth_in;
         end
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row + COL_W'(1);
         end else begin
            col_in = col + COL_W'(1);
            row_in = row;
         end
      end
   end

   // Next-state logic for the internal stage and the output register.
   always_comb begin
      s1_valid_in  = (s1_valid_ff && !out_free) || ram_re;
      s1_sum_in    = s1_sum_ff;
      s1_cnt_in    = s1_cnt_ff;
      s1_eor_in    = s1_eor_ff;
      s1_eof_in    = s1_eof_ff;
      if (ram_re) begin
         s1_sum_in = psum;
         s1_cnt_in = pcnt;
         s1_eor_in = eor;
         s1_eof_in = eof;
      end
      rsp_valid_in = (s1_valid_ff && out_free) || (rsp_valid_ff && !rsp_bus.ready);
      rsp_depth_in = rsp_depth_ff;
      rsp_eor_in   = rsp_eor_ff;
      rsp_eof_in   = rsp_eof_ff;
      if (s1_valid_ff && out_free) begin
         rsp_depth_in = mean;
         rsp_eor_in   = s1_eor_ff;
         rsp_eof_in   = s1_eof_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= SIZE_RESET;
         height_ff    <= SIZE_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         held_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         held_ff      <= held_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_sum_ff    <= s1_sum_in;
      s1_cnt_ff    <= s1_cnt_in;
      s1_eor_ff    <= s1_eor_in;
      s1_eof_ff    <= s1_eof_in;
      rsp_depth_ff <= rsp_depth_in;
      rsp_eor_ff   <= rsp_eor_in;
      rsp_eof_ff   <= rsp_eof_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.depth_out    = rsp_depth_ff;
   assign rsp_bus.end_of_row   = rsp_eor_ff;
   assign rsp_bus.end_of_frame = rsp_eof_ff;

`ifndef ASSERT_OFF
   // The last beat of a level also closes its row.
   a_eof_has_eor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_eof_ff || rsp_eor_ff))
      else $error("end_of_frame without end_of_row");

   // The column position stays inside the programmed width.
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      SIZE_W'(col_ff) < eff_w)
      else $error("column position beyond source width");

   // A pending block total is not lost while the output register is blocked.
   a_s1_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_sum_ff)))
      else $error("pending block total dropped during stall");

   // The pair store is never read and written in the same cycle.
   a_ram_one_access: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("pair store read and write in one cycle");
`endif

endmodule
